>>> hw/rtl/cwlr_pkg.sv
`timescale 1ns / 1ps

package cwlr_pkg;

   // Default build parameters
   localparam int DEF_FRACTION_BITS = 16;
   localparam int DEF_MAX_DIMENSION = 4096;

   // Fixed field widths
   localparam int COORD_W    = 32;
   localparam int COLOR_W    = 32;
   localparam int ADDR_W     = 25;
   localparam int POS_W      = 13;
   localparam int DIM_W      = 13;
   localparam int PITCH_W    = 14;
   localparam int WEIGHT_W   = 8;
   localparam int ACC_W      = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 14;

   // Result kinds
   localparam logic [1:0] KIND_PIXEL  = 2'd0;
   localparam logic [1:0] KIND_ACCEPT = 2'd1;
   localparam logic [1:0] KIND_REJECT = 2'd2;
   localparam logic [1:0] KIND_DONE   = 2'd3;

   // Request actions
   localparam logic ACTION_LOAD = 1'b0;
   localparam logic ACTION_STEP = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PITCH  = 2'd2;

   // Register reset values
   localparam logic [DIM_W-1:0]   RST_WIDTH  = 13'd640;
   localparam logic [DIM_W-1:0]   RST_HEIGHT = 13'd480;
   localparam logic [PITCH_W-1:0] RST_PITCH  = 14'd640;

   typedef struct packed {
      logic                action;
      logic [COORD_W-1:0]  start_x;
      logic [COORD_W-1:0]  start_y;
      logic [COORD_W-1:0]  end_x;
      logic [COORD_W-1:0]  end_y;
      logic [COLOR_W-1:0]  line_color;
      logic                smooth;
   } req_type;

   typedef struct packed {
      logic [1:0]          kind;
      logic [ADDR_W-1:0]   pixel_address;
      logic [COLOR_W-1:0]  pixel_color;
      logic                blend;
      logic [WEIGHT_W-1:0] old_weight;
      logic                last;
   } rsp_type;

   // Build a marker result (accept, reject, done) with empty payload
   function automatic rsp_type make_mark(input logic [1:0] kind);
      rsp_type r;
      r               = '0;
      r.kind          = kind;
      r.last          = 1'b1;
      return r;
   endfunction

endpackage

>>> hw/rtl/clipped_wu_line_rasterizer_top.sv
`timescale 1ns / 1ps

// Clipped line rasterizer with optional Wu anti-aliasing. A load request sets
// up a line from fixed-point endpoints, clips it to the box [1, size-2] and
// answers with one accept or reject result; a step request gives one plain
// pixel write, two weighted Wu pixels, or a done marker. After a step the
// block takes no new request until its last result has entered the single
// output register. A load runs through one shared multiply-divide unit of
// width W, the internal coordinate width (34 bits at the default parameters):
// up to four clip calls plus one slope call, fewer when the line is rejected
// early. The block accepts no request meanwhile.
module clipped_wu_line_rasterizer_top #(
   parameter int FRACTION_BITS = cwlr_pkg::DEF_FRACTION_BITS,
   parameter int MAX_DIMENSION = cwlr_pkg::DEF_MAX_DIMENSION
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  cwlr_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output cwlr_pkg::rsp_type                   rsp_data,
   input  logic                                csr_wr_en,
   input  logic [cwlr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [cwlr_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   import cwlr_pkg::*;

   localparam int NEED_A = $clog2(MAX_DIMENSION) + FRACTION_BITS + 1;
   localparam int NEED_B = FRACTION_BITS + 14;
   localparam int NEED_C = (NEED_A > NEED_B) ? NEED_A : NEED_B;
   localparam int CW     = (NEED_C > COORD_W) ? NEED_C : COORD_W;
   localparam int DW     = CW + 2;
   localparam logic signed [DW-1:0] UNIT_C = DW'(1) << FRACTION_BITS;
   localparam logic [PITCH_W-1:0]   MAXD_C = PITCH_W'(MAX_DIMENSION);

   typedef enum logic [6:0] {
      S_IDLE       = 7'b0000001,
      S_CHECK      = 7'b0000010,
      S_CLIP       = 7'b0000100,
      S_CLIP_WAIT  = 7'b0001000,
      S_SLOPE      = 7'b0010000,
      S_SLOPE_WAIT = 7'b0100000,
      S_EMIT       = 7'b1000000
   } state_type;

   state_type               state_ff, state_in;
   logic [1:0]              pass_ff, pass_in;
   logic [3:0]              clip_pend_ff, clip_pend_in;
   logic signed [DW-1:0]    ax_ff, ax_in, ay_ff, ay_in, bx_ff, bx_in, by_ff, by_in;
   logic                    x_major_ff, x_major_in;
   logic                    smooth_mode_ff, smooth_mode_in;
   logic [COLOR_W-1:0]      stored_color_ff, stored_color_in;
   logic [POS_W-1:0]        major_position_ff, major_position_in;
   logic [POS_W-1:0]        major_end_ff, major_end_in;
   logic [ACC_W-1:0]        minor_acc_ff, minor_acc_in;
   logic [ACC_W-1:0]        minor_slope_ff, minor_slope_in;
   logic                    line_active_ff, line_active_in;
   rsp_type                 pend_ff, pend_in;
   rsp_type                 sec_ff, sec_in;
   logic                    second_ff, second_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;
   logic [DIM_W-1:0]        width_ff, height_ff;
   logic [PITCH_W-1:0]      pitch_ff;

   // Clip box
   logic [PITCH_W-1:0]      w_eff, h_eff;
   logic                    box_empty;
   logic signed [DW-1:0]    mx, my;

   // Length and outcode check
   logic signed [DW-1:0]    dx, dy;
   logic [DW-1:0]           adx, ady, len;
   logic [3:0]              ca, cb;

   // Clip operand selection
   logic [1:0]              clip_idx;
   logic                    tgt_a, to_low, axis_x;
   logic signed [DW-1:0]    cm, cn, com, con, bound;

   // Slope setup
   logic signed [DW-1:0]    am0, an0, bm0, bn0, am, an, bm, bn;
   logic                    swap;

   // Shared unit
   logic                    mdu_start, mdu_done;
   logic signed [DW-1:0]    mdu_p, mdu_q, mdu_d, mdu_res;

   // Step arithmetic
   logic signed [ACC_W-1:0] acc_s, minor_full;
   logic [ADDR_W-1:0]       minor25, mul_a, step2, pix_addr;
   logic [ADDR_W+PITCH_W-1:0] prod_full;
   logic [WEIGHT_W-1:0]     fract;
   logic                    slot_free;

   assign w_eff     = ({1'b0, width_ff} > MAXD_C) ? MAXD_C : {1'b0, width_ff};
   assign h_eff     = ({1'b0, height_ff} > MAXD_C) ? MAXD_C : {1'b0, height_ff};
   assign box_empty = (w_eff < PITCH_W'(3)) || (h_eff < PITCH_W'(3));
   assign mx        = signed'((DW'(w_eff) - DW'(2)) << FRACTION_BITS);
   assign my        = signed'((DW'(h_eff) - DW'(2)) << FRACTION_BITS);

   assign dx  = bx_ff - ax_ff;
   assign dy  = by_ff - ay_ff;
   assign adx = dx[DW-1] ? DW'(-dx) : DW'(dx);
   assign ady = dy[DW-1] ? DW'(-dy) : DW'(dy);
   assign len = adx + ady;
   assign ca  = {ay_ff > my, ay_ff < UNIT_C, ax_ff > mx, ax_ff < UNIT_C};
   assign cb  = {by_ff > my, by_ff < UNIT_C, bx_ff > mx, bx_ff < UNIT_C};

   // Pick the first pending clip: a low, a high, b low, b high
   always_comb begin
      if (clip_pend_ff[0]) begin
         clip_idx = 2'd0;
      end else if (clip_pend_ff[1]) begin
         clip_idx = 2'd1;
      end else if (clip_pend_ff[2]) begin
         clip_idx = 2'd2;
      end else begin
         clip_idx = 2'd3;
      end
   end

   assign tgt_a  = ~clip_idx[1];
   assign to_low = ~clip_idx[0];
   assign axis_x = (pass_ff == 2'd0);

   always_comb begin
      if (axis_x) begin
         cm  = tgt_a ? ax_ff : bx_ff;
         cn  = tgt_a ? ay_ff : by_ff;
         com = tgt_a ? bx_ff : ax_ff;
         con = tgt_a ? by_ff : ay_ff;
      end else begin
         cm  = tgt_a ? ay_ff : by_ff;
         cn  = tgt_a ? ax_ff : bx_ff;
         com = tgt_a ? by_ff : ay_ff;
         con = tgt_a ? bx_ff : ax_ff;
      end
      bound = to_low ? UNIT_C : (axis_x ? mx : my);
   end

   // Order endpoints along the major axis
   assign am0  = x_major_ff ? ax_ff : ay_ff;
   assign an0  = x_major_ff ? ay_ff : ax_ff;
   assign bm0  = x_major_ff ? bx_ff : by_ff;
   assign bn0  = x_major_ff ? by_ff : bx_ff;
   assign swap = bm0 < am0;
   assign am   = swap ? bm0 : am0;
   assign an   = swap ? bn0 : an0;
   assign bm   = swap ? am0 : bm0;
   assign bn   = swap ? an0 : bn0;

   // Feed the shared unit: clip offset or slope
   always_comb begin
      mdu_start = 1'b0;
      mdu_p     = con - cn;
      mdu_q     = bound - cm;
      mdu_d     = com - cm;
      if (state_ff == S_SLOPE) begin
         mdu_start = 1'b1;
         mdu_p     = bn - an;
         mdu_q     = UNIT_C;
         mdu_d     = bm - am;
      end else if ((state_ff == S_CLIP) && (clip_pend_ff != 4'd0)) begin
         mdu_start = 1'b1;
      end
   end

   cwlr_mdu #(
      .OW (DW)
   ) u_mdu (
      .clock  (clock),
      .reset  (reset),
      .start  (mdu_start),
      .op_p   (mdu_p),
      .op_q   (mdu_q),
      .op_d   (mdu_d),
      .done   (mdu_done),
      .result (mdu_res)
   );

   // Pixel address and weight for the current step
   assign acc_s      = signed'(minor_acc_ff);
   assign minor_full = acc_s >>> FRACTION_BITS;
   assign minor25    = minor_full[ADDR_W-1:0];
   assign mul_a      = x_major_ff ? minor25 : ADDR_W'(major_position_ff);
   assign prod_full  = mul_a * pitch_ff;
   assign pix_addr   = prod_full[ADDR_W-1:0] +
                       (x_major_ff ? ADDR_W'(major_position_ff) : minor25);
   assign step2      = x_major_ff ? ADDR_W'(pitch_ff) : ADDR_W'(1);
   assign fract      = minor_acc_ff[FRACTION_BITS-1 -: WEIGHT_W];

   assign slot_free  = !rsp_valid_ff || rsp_ready;

   // Sequencer
   always_comb begin
      state_in          = state_ff;
      pass_in           = pass_ff;
      clip_pend_in      = clip_pend_ff;
      ax_in             = ax_ff;
      ay_in             = ay_ff;
      bx_in             = bx_ff;
      by_in             = by_ff;
      x_major_in        = x_major_ff;
      smooth_mode_in    = smooth_mode_ff;
      stored_color_in   = stored_color_ff;
      major_position_in = major_position_ff;
      major_end_in      = major_end_ff;
      minor_acc_in      = minor_acc_ff;
      minor_slope_in    = minor_slope_ff;
      line_active_in    = line_active_ff;
      pend_in           = pend_ff;
      sec_in            = sec_ff;
      second_in         = second_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_data_in       = rsp_data_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_data.action == ACTION_LOAD) begin
                  line_active_in  = 1'b0;
                  ax_in           = DW'(signed'(req_data.start_x));
                  ay_in           = DW'(signed'(req_data.start_y));
                  bx_in           = DW'(signed'(req_data.end_x));
                  by_in           = DW'(signed'(req_data.end_y));
                  stored_color_in = req_data.line_color;
                  smooth_mode_in  = req_data.smooth;
                  pass_in         = 2'd0;
                  second_in       = 1'b0;
                  if (box_empty) begin
                     pend_in  = make_mark(KIND_REJECT);
                     state_in = S_EMIT;
                  end else begin
                     state_in = S_CHECK;
                  end
               end else if (!line_active_ff || (major_position_ff >= major_end_ff)) begin
                  line_active_in = 1'b0;
                  second_in      = 1'b0;
                  pend_in        = make_mark(KIND_DONE);
                  state_in       = S_EMIT;
               end else begin
                  pend_in.kind          = KIND_PIXEL;
                  pend_in.pixel_address = pix_addr;
                  sec_in.kind           = KIND_PIXEL;
                  sec_in.pixel_address  = pix_addr + step2;
                  sec_in.pixel_color    = {8'h00, stored_color_ff[23:0]};
                  sec_in.blend          = 1'b1;
                  sec_in.old_weight     = fract ^ 8'hff;
                  sec_in.last           = 1'b1;
                  if (smooth_mode_ff) begin
                     pend_in.pixel_color = {8'h00, stored_color_ff[23:0]};
                     pend_in.blend       = 1'b1;
                     pend_in.old_weight  = fract;
                     pend_in.last        = 1'b0;
                  end else begin
                     pend_in.pixel_color = stored_color_ff;
                     pend_in.blend       = 1'b0;
                     pend_in.old_weight  = '0;
                     pend_in.last        = 1'b1;
                  end
                  second_in         = smooth_mode_ff;
                  major_position_in = major_position_ff + 1'b1;
                  minor_acc_in      = minor_acc_ff + minor_slope_ff;
                  state_in          = S_EMIT;
               end
            end
         end
         S_CHECK: begin
            if (len < DW'(UNIT_C)) begin
               pend_in  = make_mark(KIND_REJECT);
               state_in = S_EMIT;
            end else if ((ca | cb) == 4'd0) begin
               x_major_in = adx > ady;
               state_in   = S_SLOPE;
            end else if (((ca & cb) != 4'd0) || (pass_ff == 2'd2)) begin
               pend_in  = make_mark(KIND_REJECT);
               state_in = S_EMIT;
            end else begin
               clip_pend_in = (pass_ff == 2'd0) ? {cb[1:0], ca[1:0]} : {cb[3:2], ca[3:2]};
               state_in     = S_CLIP;
            end
         end
         S_CLIP: begin
            if (clip_pend_ff == 4'd0) begin
               pass_in  = pass_ff + 1'b1;
               state_in = S_CHECK;
            end else begin
               state_in = S_CLIP_WAIT;
            end
         end
         S_CLIP_WAIT: begin
            if (mdu_done) begin
               if (axis_x && tgt_a) begin
                  ax_in = bound;
                  ay_in = ay_ff + mdu_res;
               end else if (axis_x) begin
                  bx_in = bound;
                  by_in = by_ff + mdu_res;
               end else if (tgt_a) begin
                  ay_in = bound;
                  ax_in = ax_ff + mdu_res;
               end else begin
                  by_in = bound;
                  bx_in = bx_ff + mdu_res;
               end
               clip_pend_in           = clip_pend_ff;
               clip_pend_in[clip_idx] = 1'b0;
               state_in               = S_CLIP;
            end
         end
         S_SLOPE: begin
            major_position_in = am[FRACTION_BITS +: POS_W];
            major_end_in      = bm[FRACTION_BITS +: POS_W];
            minor_acc_in      = an[ACC_W-1:0];
            state_in          = S_SLOPE_WAIT;
         end
         S_SLOPE_WAIT: begin
            if (mdu_done) begin
               minor_slope_in = mdu_res[ACC_W-1:0];
               line_active_in = 1'b1;
               pend_in        = make_mark(KIND_ACCEPT);
               state_in       = S_EMIT;
            end
         end
         S_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = pend_ff;
               if (second_ff) begin
                  pend_in   = sec_ff;
                  second_in = 1'b0;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         pass_ff           <= '0;
         clip_pend_ff      <= '0;
         second_ff         <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         line_active_ff    <= 1'b0;
         x_major_ff        <= 1'b0;
         smooth_mode_ff    <= 1'b0;
         stored_color_ff   <= '0;
         major_position_ff <= '0;
         major_end_ff      <= '0;
         minor_acc_ff      <= '0;
         minor_slope_ff    <= '0;
      end else begin
         state_ff          <= state_in;
         pass_ff           <= pass_in;
         clip_pend_ff      <= clip_pend_in;
         second_ff         <= second_in;
         rsp_valid_ff      <= rsp_valid_in;
         line_active_ff    <= line_active_in;
         x_major_ff        <= x_major_in;
         smooth_mode_ff    <= smooth_mode_in;
         stored_color_ff   <= stored_color_in;
         major_position_ff <= major_position_in;
         major_end_ff      <= major_end_in;
         minor_acc_ff      <= minor_acc_in;
         minor_slope_ff    <= minor_slope_in;
      end
      ax_ff       <= ax_in;
      ay_ff       <= ay_in;
      bx_ff       <= bx_in;
      by_ff       <= by_in;
      pend_ff     <= pend_in;
      sec_ff      <= sec_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RST_WIDTH;
         height_ff <= RST_HEIGHT;
         pitch_ff  <= RST_PITCH;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_WIDTH:  width_ff  <= csr_wdata[DIM_W-1:0];
            CSR_HEIGHT: height_ff <= csr_wdata[DIM_W-1:0];
            CSR_PITCH:  pitch_ff  <= csr_wdata;
            default: begin
               width_ff <= width_ff;
            end
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_mdu_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      mdu_done |-> ((state_ff == S_CLIP_WAIT) || (state_ff == S_SLOPE_WAIT)))
      else $error("divide result arrived outside a wait state");

   a_busy_after_request: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != S_IDLE))
      else $error("request accepted without leaving idle");

   a_second_only_smooth: assert property (@(posedge clock) disable iff (reset)
      second_ff |-> (smooth_mode_ff && (state_ff == S_EMIT)))
      else $error("second Wu pixel pending outside a smooth step");
`endif

endmodule

>>> hw/rtl/cwlr_mdu.sv
`timescale 1ns / 1ps

// Iterative signed multiply-divide: result = p * q / d, truncated toward zero,
// zero when d is zero. Shift-add multiply, then restoring division of the
// double-width product.
module cwlr_mdu #(
   parameter int OW = 34
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [OW-1:0] op_p,
   input  logic signed [OW-1:0] op_q,
   input  logic signed [OW-1:0] op_d,
   output logic                 done,
   output logic signed [OW-1:0] result
);

   localparam int CNT_W = $clog2(2 * OW);

   typedef enum logic [2:0] {
      M_IDLE = 3'b001,
      M_MUL  = 3'b010,
      M_DIV  = 3'b100
   } mstate_type;

   mstate_type          state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [2*OW-1:0]     mcand_ff, mcand_in;
   logic [OW-1:0]       mplier_ff, mplier_in;
   logic [2*OW-1:0]     prod_ff, prod_in;
   logic [OW-1:0]       div_ff, div_in;
   logic [OW-1:0]       rem_ff, rem_in;
   logic [OW-1:0]       quo_ff, quo_in;
   logic                neg_ff, neg_in;
   logic                zero_ff, zero_in;
   logic                done_ff, done_in;

   logic [OW-1:0]       abs_p, abs_q, abs_d;
   logic [OW:0]         rem_shift;
   logic                rem_ge;

   assign abs_p = op_p[OW-1] ? OW'(-op_p) : OW'(op_p);
   assign abs_q = op_q[OW-1] ? OW'(-op_q) : OW'(op_q);
   assign abs_d = op_d[OW-1] ? OW'(-op_d) : OW'(op_d);

   // Bring down the next dividend bit and trial-compare
   assign rem_shift = {rem_ff, prod_ff[2*OW-1]};
   assign rem_ge    = rem_shift >= {1'b0, div_ff};

   // Sequence multiply then divide
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      prod_in   = prod_ff;
      div_in    = div_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      neg_in    = neg_ff;
      zero_in   = zero_ff;
      done_in   = 1'b0;
      case (state_ff)
         M_IDLE: begin
            if (start) begin
               mcand_in  = {{OW{1'b0}}, abs_p};
               mplier_in = abs_q;
               prod_in   = '0;
               div_in    = abs_d;
               neg_in    = op_p[OW-1] ^ op_q[OW-1] ^ op_d[OW-1];
               zero_in   = (op_d == '0);
               cnt_in    = '0;
               state_in  = M_MUL;
            end
         end
         M_MUL: begin
            if (mplier_ff[0]) begin
               prod_in = prod_ff + mcand_ff;
            end
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            if (cnt_ff == CNT_W'(OW - 1)) begin
               cnt_in   = '0;
               rem_in   = '0;
               quo_in   = '0;
               state_in = M_DIV;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         M_DIV: begin
            rem_in  = rem_ge ? OW'(rem_shift - {1'b0, div_ff}) : rem_shift[OW-1:0];
            quo_in  = {quo_ff[OW-2:0], rem_ge};
            prod_in = prod_ff << 1;
            if (cnt_ff == CNT_W'(2 * OW - 1)) begin
               done_in  = 1'b1;
               state_in = M_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         default: begin
            state_in = M_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff    <= cnt_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      prod_ff   <= prod_in;
      div_ff    <= div_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      neg_ff    <= neg_in;
      zero_ff   <= zero_in;
   end

   assign done   = done_ff;
   assign result = zero_ff ? '0 : (neg_ff ? -signed'(quo_ff) : signed'(quo_ff));

endmodule

>>> verif/clipped_wu_line_rasterizer_top_tb.sv
`timescale 1ns / 1ps

module clipped_wu_line_rasterizer_top_tb;
   import cwlr_pkg::*;

   localparam int  FB          = DEF_FRACTION_BITS;
   localparam int  MAXD        = DEF_MAX_DIMENSION;
   localparam longint UNIT     = longint'(1) << FB;
   localparam int  LOAD_CYCLES = 700;
   localparam longint CYCLE_LIMIT = 1_500_000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_WIDTH;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   clipped_wu_line_rasterizer_top u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Rasterizer shadow state
   longint surf_w, surf_h, pitch;
   bit     line_on, along_x, wu_mode;
   logic [31:0] line_rgb;
   logic [12:0] major_pos, major_stop;
   logic [31:0] minor_acc, minor_step;

   rsp_type pending_pixels[$];
   int     errors, requests_sent, results_seen;
   int     lines_taken, lines_refused, pixels_seen;
   longint cycles;
   bit     stall_on;

   // Cycle guard
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Receiver stalls in phases, with quiet stretches in between
   always @(negedge clock) begin
      if (($urandom % 160) == 0) stall_on <= ~stall_on;
      rsp_ready <= stall_on ? ($urandom_range(0, 2) != 0) : 1'b1;
   end

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
   endtask

   // Compare each accepted result with the oldest pending one
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (pending_pixels.size() == 0) begin
            report_mismatch($sformatf("unexpected result %h", rsp_data));
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_data.kind != want.kind)
               report_mismatch($sformatf("kind %0d want %0d", rsp_data.kind, want.kind));
            if (rsp_data.pixel_address != want.pixel_address)
               report_mismatch($sformatf("address %h want %h",
                  rsp_data.pixel_address, want.pixel_address));
            if (rsp_data.pixel_color != want.pixel_color)
               report_mismatch($sformatf("colour %h want %h",
                  rsp_data.pixel_color, want.pixel_color));
            if (rsp_data.blend != want.blend)
               report_mismatch($sformatf("blend %0b want %0b", rsp_data.blend, want.blend));
            if (rsp_data.old_weight != want.old_weight)
               report_mismatch($sformatf("weight %h want %h",
                  rsp_data.old_weight, want.old_weight));
            if (rsp_data.last != want.last)
               report_mismatch($sformatf("last %0b want %0b", rsp_data.last, want.last));
            if (rsp_data.kind == KIND_PIXEL) pixels_seen++;
         end
      end
   end

   // p*q/d truncated toward zero, zero for a zero divisor
   function automatic longint scaled_div(input longint p, input longint q, input longint d);
      logic [127:0] prod, quot;
      bit neg;
      if (d == 0) return 0;
      neg = (p < 0) != (q < 0);
      if (d < 0) neg = !neg;
      prod = 128'(p < 0 ? -p : p) * 128'(q < 0 ? -q : q);
      quot = prod / 128'(d < 0 ? -d : d);
      quot[127:62] = '0;
      return neg ? -longint'(quot[63:0]) : longint'(quot[63:0]);
   endfunction

   // Slide endpoint (m, n) along the line until m sits on the bound
   function automatic void clip_to(inout longint m, inout longint n,
                                   input longint om, input longint on, input longint bound);
      n = n + scaled_div(on - n, bound - m, om - m);
      m = bound;
   endfunction

   function automatic int outcode(input longint x, input longint y,
                                  input longint mx, input longint my);
      return (x < UNIT ? 1 : 0) | (x > mx ? 2 : 0) | (y < UNIT ? 4 : 0) | (y > my ? 8 : 0);
   endfunction

   function automatic longint absl(input longint v);
      return v < 0 ? -v : v;
   endfunction

   // Clip, pick the major axis and set up the stepper; 0 means rejected
   function automatic bit setup_line(input req_type r);
      longint ax, ay, bx, by, w, h, mx, my, am, an, bm, bn, t, slope;
      int ca, cb;
      bit in_box;
      ax = longint'($signed(r.start_x));
      ay = longint'($signed(r.start_y));
      bx = longint'($signed(r.end_x));
      by = longint'($signed(r.end_y));
      w = surf_w > MAXD ? MAXD : surf_w;
      h = surf_h > MAXD ? MAXD : surf_h;
      mx = (w - 2) * UNIT;
      my = (h - 2) * UNIT;
      in_box = 0;
      for (int pass = 0; pass < 3 && !in_box; pass++) begin
         if (absl(bx - ax) + absl(by - ay) < UNIT) return 0;
         ca = outcode(ax, ay, mx, my);
         cb = outcode(bx, by, mx, my);
         if ((ca | cb) == 0) in_box = 1;
         else if ((ca & cb) != 0 || pass == 2) return 0;
         else if (pass == 0) begin
            if (ca & 1) clip_to(ax, ay, bx, by, UNIT);
            if (ca & 2) clip_to(ax, ay, bx, by, mx);
            if (cb & 1) clip_to(bx, by, ax, ay, UNIT);
            if (cb & 2) clip_to(bx, by, ax, ay, mx);
         end else begin
            if (ca & 4) clip_to(ay, ax, by, bx, UNIT);
            if (ca & 8) clip_to(ay, ax, by, bx, my);
            if (cb & 4) clip_to(by, bx, ay, ax, UNIT);
            if (cb & 8) clip_to(by, bx, ay, ax, my);
         end
      end
      along_x = absl(bx - ax) > absl(by - ay);
      if (along_x) begin am = ax; an = ay; bm = bx; bn = by; end
      else begin am = ay; an = ax; bm = by; bn = bx; end
      if (bm < am) begin
         t = am; am = bm; bm = t;
         t = an; an = bn; bn = t;
      end
      slope = scaled_div(bn - an, UNIT, bm - am);
      major_pos = 13'(am >>> FB);
      major_stop = 13'(bm >>> FB);
      minor_acc = 32'(an);
      minor_step = 32'(slope);
      wu_mode = r.smooth;
      line_rgb = r.line_color;
      return 1;
   endfunction

   // Work out the results one accepted request causes
   function automatic void predict_request(input req_type r);
      rsp_type o;
      longint minor, addr, next_off;
      logic [7:0] frac;
      o = '0;
      o.last = 1'b1;
      if (r.action == ACTION_LOAD) begin
         line_on = setup_line(r);
         o.kind = line_on ? KIND_ACCEPT : KIND_REJECT;
         if (line_on) lines_taken++; else lines_refused++;
         pending_pixels.push_back(o);
         return;
      end
      if (!line_on || major_pos >= major_stop) begin
         line_on = 0;
         o.kind = KIND_DONE;
         pending_pixels.push_back(o);
         return;
      end
      minor = longint'($signed(minor_acc)) >>> FB;
      if (along_x) begin
         addr = longint'(major_pos) + minor * pitch;
         next_off = pitch;
      end else begin
         addr = minor + longint'(major_pos) * pitch;
         next_off = 1;
      end
      frac = minor_acc[FB-1 -: 8];
      major_pos = major_pos + 13'd1;
      minor_acc = minor_acc + minor_step;
      o.kind = KIND_PIXEL;
      o.pixel_address = ADDR_W'(addr);
      if (!wu_mode) begin
         o.pixel_color = line_rgb;
         pending_pixels.push_back(o);
         return;
      end
      o.pixel_color = {8'h00, line_rgb[23:0]};
      o.blend = 1'b1;
      o.old_weight = frac;
      o.last = 1'b0;
      pending_pixels.push_back(o);
      o.pixel_address = ADDR_W'(addr + next_off);
      o.old_weight = frac ^ 8'hff;
      o.last = 1'b1;
      pending_pixels.push_back(o);
   endfunction

   // Send one request; hold valid into the next request unless a gap is drawn
   task automatic send_request(input req_type r);
      req_data = r;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      predict_request(r);
      requests_sent++;
      @(negedge clock);
      if ($urandom_range(0, 4) == 0) begin
         req_valid = 1'b0;
         req_data = '0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
   endtask

   // Drop valid at once, then let every result drain
   task automatic wait_idle();
      req_valid = 1'b0;
      while (pending_pixels.size() != 0) @(negedge clock);
      repeat (LOAD_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input longint value);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = CSR_DATA_W'(value);
      @(negedge clock);
      csr_wr_en = 1'b0;
      if (idx == CSR_WIDTH) surf_w = value & 16'h1fff;
      else if (idx == CSR_HEIGHT) surf_h = value & 16'h1fff;
      else pitch = value & 16'h3fff;
   endtask

   function automatic logic [31:0] fx(input int px, input int frac = 0);
      return 32'(longint'(px) * UNIT + frac);
   endfunction

   function automatic req_type line_req(input logic [31:0] sx, sy, ex, ey,
                                        input logic [31:0] rgb, input bit wu);
      req_type r;
      r = '{action: ACTION_LOAD, start_x: sx, start_y: sy, end_x: ex, end_y: ey,
            line_color: rgb, smooth: wu};
      return r;
   endfunction

   function automatic req_type step_req();
      req_type r;
      r = '{action: ACTION_STEP, start_x: $urandom, start_y: $urandom, end_x: $urandom,
            end_y: $urandom, line_color: $urandom, smooth: 1'($urandom_range(0, 1))};
      return r;
   endfunction

   task automatic send_steps(input int n);
      repeat (n) send_request(step_req());
   endtask

   // Degenerate loads and steps with no line
   task automatic test_degenerate();
      send_steps(1);
      send_request(line_req(fx(10), fx(10), fx(10), fx(10), 32'hffffffff, 1));
      send_request(line_req(fx(10), fx(10), fx(10, 16'h7fff), fx(10), 32'h0, 0));
      send_request(line_req(fx(-50), fx(5), fx(-3), fx(60), 32'h12345678, 0));
      send_request(line_req(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                            32'hdeadbeef, 1));
      send_steps(2);
   endtask

   // Plain and Wu lines on both axes; the first two run past their end, the last stops short
   task automatic test_lines();
      send_request(line_req(fx(3, 16'h8000), fx(4), fx(9), fx(6, 16'hc000),
                            32'hff00ff00, 0));
      send_steps(8);
      send_request(line_req(fx(5), fx(5), fx(9, 16'h4000), fx(9, 16'h4000),
                            32'h80ff00ff, 1));
      send_steps(6);
      send_request(line_req(fx(12), fx(2), fx(4), fx(6), 32'h00ffffff, 1));
      send_steps(4);
   endtask

   // Lines crossing the box edges to drive the clip paths
   task automatic test_clipping();
      send_request(line_req(fx(-20), fx(-30), fx(700), fx(500), 32'h11223344, 1));
      send_steps(3);
      send_request(line_req(fx(630), fx(470), fx(-4), fx(20), 32'h55667788, 0));
      send_steps(3);
   endtask

   function automatic int pick_coord(input longint size);
      longint top;
      top = (size > MAXD ? MAXD : size);
      return $urandom_range(0, 7) == 0 ? int'($urandom_range(0, 40)) - 20
                                       : int'($urandom_range(0, 32'(top + 4)));
   endfunction

   // Mostly short lines around points in the box followed by steps, some long crossing lines and noise loads
   task automatic test_random(input int count, input bit pause_once);
      int sx, sy, span, done_items;
      bit paused;
      req_type r;
      done_items = 0;
      paused = 0;
      while (done_items < count) begin
         sx = pick_coord(surf_w);
         sy = pick_coord(surf_h);
         span = $urandom_range(0, 3) == 0 ? 3 : 30;
         case ($urandom_range(0, 9))
            0: r = line_req($urandom, $urandom, $urandom, $urandom, $urandom,
                            1'($urandom_range(0, 1)));
            1: r = line_req(fx(sx, $urandom_range(0, 16'hffff)), fx(sy),
                            fx(sx + 600), fx(sy - 900), $urandom,
                            1'($urandom_range(0, 1)));
            default: r = line_req(fx(sx, $urandom_range(0, 16'hffff)),
                                  fx(sy, $urandom_range(0, 16'hffff)),
                                  fx(sx + $urandom_range(0, 2 * span) - span,
                                     $urandom_range(0, 16'hffff)),
                                  fx(sy + $urandom_range(0, 2 * span) - span,
                                     $urandom_range(0, 16'hffff)),
                                  $urandom, 1'($urandom_range(0, 1)));
         endcase
         send_request(r);
         span = $urandom_range(0, 24);
         send_steps(span);
         done_items += span + 1;
         // Hold off once until every pending result has drained
         if (pause_once && !paused && done_items > count / 2) begin
            paused = 1;
            req_valid = 1'b0;
            while (pending_pixels.size() != 0) @(negedge clock);
         end
      end
   endtask

   initial begin
      surf_w = RST_WIDTH;
      surf_h = RST_HEIGHT;
      pitch = RST_PITCH;
      line_on = 0; along_x = 0; wu_mode = 0; line_rgb = '0;
      major_pos = '0; major_stop = '0; minor_acc = '0; minor_step = '0;
      errors = 0; requests_sent = 0; results_seen = 0;
      lines_taken = 0; lines_refused = 0; pixels_seen = 0;
      cycles = 0;
      stall_on = 0;
      repeat (7) @(negedge clock);
      reset = 1'b0;

      test_degenerate();
      test_lines();
      test_clipping();
      test_random(150, 1);

      // Smallest useful box, tight pitch
      wait_idle();
      write_reg(CSR_WIDTH, 4);
      write_reg(CSR_HEIGHT, 4);
      write_reg(CSR_PITCH, 4);
      test_random(60, 0);

      // Oversized surface and widest pitch
      wait_idle();
      write_reg(CSR_WIDTH, 8191);
      write_reg(CSR_HEIGHT, 4096);
      write_reg(CSR_PITCH, 16383);
      test_random(110, 0);

      // Empty box rejects everything
      wait_idle();
      write_reg(CSR_WIDTH, 2);
      write_reg(CSR_HEIGHT, 0);
      test_random(20, 0);

      // Odd sizes with a power-of-two pitch
      wait_idle();
      write_reg(CSR_WIDTH, 97);
      write_reg(CSR_HEIGHT, 8191);
      write_reg(CSR_PITCH, 8192);
      test_random(80, 0);

      wait_idle();
      $display("Covered %0d requests, %0d results: %0d lines accepted, %0d rejected,",
               requests_sent, results_seen, lines_taken, lines_refused);
      $display("  %0d pixel writes over five surface settings", pixels_seen);
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

>>> clipped_wu_line_rasterizer_top.f
hw/rtl/cwlr_pkg.sv
hw/rtl/cwlr_mdu.sv
hw/rtl/clipped_wu_line_rasterizer_top.sv
verif/clipped_wu_line_rasterizer_top_tb.sv
